>>> hdl/ddmf_pkg.sv
// Package for the decimal digit mode finder: item types, sequencer control word,
// status word and constants. No dependencies.
`default_nettype none
package ddmf_pkg;

    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned DIG_W      = 4;
    localparam int unsigned CNT_W      = 18;
    localparam int unsigned MAG_W      = 32;
    localparam int unsigned PC_W       = 3;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NUM_DIGITS - 1);

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_element;
    } t_in_item;

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic [CNT_W-1:0] occurrences;
        logic             final_digit;
    } t_out_item;

    typedef enum logic [2:0] {
        C_NOSTART,
        C_QNZ,
        C_NOTLAST,
        C_IDXMORE,
        C_ALWAYS,
        C_NEVER
    } t_cond;

    typedef struct packed {
        logic            load;
        logic            divide;
        logic            bump;
        logic            init;
        logic            scan;
        logic            emit;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic q_nz;
        logic last;
        logic idx_more;
    } t_stat;

endpackage
`default_nettype wire

>>> hdl/ddmf_div10.sv
// Divide a 32-bit magnitude by ten: reciprocal multiply, remainder by shift-add.
// Depends on ddmf_pkg.
`default_nettype none
module ddmf_div10 (
    input  wire logic [ddmf_pkg::MAG_W-1:0] i_mag,
    output logic      [ddmf_pkg::MAG_W-1:0] o_quot,
    output logic      [ddmf_pkg::DIG_W-1:0] o_rem
);
    import ddmf_pkg::*;

    logic [2*MAG_W-1:0] prod;
    logic [MAG_W-1:0]   quot_x10;
    logic [MAG_W-1:0]   rem_full;

    always_comb begin
        prod     = {{MAG_W{1'b0}}, i_mag} * {{MAG_W{1'b0}}, 32'hCCCC_CCCD};
        o_quot   = MAG_W'(prod >> 35);
        quot_x10 = (o_quot << 3) + (o_quot << 1);
        rem_full = i_mag - quot_x10;
        o_rem    = rem_full[DIG_W-1:0];
    end

endmodule
`default_nettype wire

>>> hdl/ddmf_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on ddmf_pkg.
`default_nettype none
module ddmf_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire ddmf_pkg::t_stat i_stat,
    output ddmf_pkg::t_ctl       o_ctl,
    output logic                 busy
);
    import ddmf_pkg::*;

    localparam logic [PC_W-1:0] P_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] P_DIV   = 3'd1;
    localparam logic [PC_W-1:0] P_DRAIN = 3'd2;
    localparam logic [PC_W-1:0] P_MAX   = 3'd3;
    localparam logic [PC_W-1:0] P_EMIT  = 3'd4;
    localparam logic [PC_W-1:0] P_DONE  = 3'd5;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctl            cw;
    logic            take;

    function automatic t_ctl rom(input logic [PC_W-1:0] pc);
        t_ctl w;
        w = '{load: 1'b0, divide: 1'b0, bump: 1'b0, init: 1'b0, scan: 1'b0,
              emit: 1'b0, cond: C_NEVER, target: P_IDLE};
        unique case (pc)
            P_IDLE: begin
                w.load = 1'b1; w.cond = C_NOSTART; w.target = P_IDLE;
            end
            P_DIV: begin
                w.divide = 1'b1; w.bump = 1'b1; w.cond = C_QNZ; w.target = P_DIV;
            end
            P_DRAIN: begin
                w.bump = 1'b1; w.init = 1'b1; w.cond = C_NOTLAST; w.target = P_IDLE;
            end
            P_MAX: begin
                w.scan = 1'b1; w.cond = C_IDXMORE; w.target = P_MAX;
            end
            P_EMIT: begin
                w.emit = 1'b1; w.cond = C_IDXMORE; w.target = P_EMIT;
            end
            P_DONE: begin
                w.cond = C_ALWAYS; w.target = P_IDLE;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = P_IDLE;
            end
        endcase
        return w;
    endfunction

    assign cw   = rom(r_pc);
    assign busy = (r_pc != P_IDLE);

    always_comb begin
        unique case (cw.cond)
            C_NOSTART: take = !start;
            C_QNZ:     take = i_stat.q_nz;
            C_NOTLAST: take = !i_stat.last;
            C_IDXMORE: take = i_stat.idx_more;
            C_ALWAYS:  take = 1'b1;
            C_NEVER:   take = 1'b0;
            default:   take = 1'b1;
        endcase
        n_pc = take ? cw.target : r_pc + 1'b1;
    end

    always_comb begin
        o_ctl      = cw;
        o_ctl.load = cw.load && start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ddmf_dp.sv
// Datapath: magnitude register, digit extraction, digit counters, max scan
// and result register. Depends on ddmf_pkg and ddmf_div10.
`default_nettype none
module ddmf_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ddmf_pkg::t_ctl       i_ctl,
    input  wire ddmf_pkg::t_in_item   i_item,
    output ddmf_pkg::t_stat           o_stat,
    output logic                      o_strobe,
    output ddmf_pkg::t_out_item       o_result
);
    import ddmf_pkg::*;

    logic [MAG_W-1:0] r_mag;
    logic             r_last;
    logic [DIG_W-1:0] r_dig;
    logic             r_pend;
    logic [CNT_W-1:0] r_cnt [NUM_DIGITS];
    logic [DIG_W-1:0] r_idx;
    logic [CNT_W-1:0] r_best;
    logic [DIG_W-1:0] r_lastidx;
    logic             r_strobe;
    t_out_item        r_result;

    logic [MAG_W-1:0] quot;
    logic [DIG_W-1:0] rem;
    logic [MAG_W-1:0] in_raw;
    logic [MAG_W-1:0] in_mag;
    logic [DIG_W-1:0] addr;
    logic [CNT_W-1:0] cnt_rd;
    logic [DIG_W-1:0] idx_next;

    ddmf_div10 u_div10 (
        .i_mag  (r_mag),
        .o_quot (quot),
        .o_rem  (rem)
    );

    always_comb begin
        in_raw   = MAG_W'(i_item.value);
        in_mag   = in_raw[MAG_W-1] ? (MAG_W'(0) - in_raw) : in_raw;
        addr     = (i_ctl.scan || i_ctl.emit) ? r_idx : r_dig;
        cnt_rd   = r_cnt[addr];
        idx_next = (r_idx == DIG_LAST) ? '0 : r_idx + 1'b1;
        o_stat.q_nz     = (quot != '0);
        o_stat.last     = r_last;
        o_stat.idx_more = (r_idx != DIG_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag  <= in_mag;
            r_last <= i_item.last_element;
        end else if (i_ctl.divide) begin
            r_mag <= quot;
            r_dig <= rem;
        end
        if (i_ctl.scan) begin
            if (cnt_rd > r_best) begin
                r_best    <= cnt_rd;
                r_lastidx <= r_idx;
            end else if (cnt_rd == r_best) begin
                r_lastidx <= r_idx;
            end
        end else if (i_ctl.init) begin
            r_best    <= '0;
            r_lastidx <= '0;
        end
        r_result.digit       <= r_idx;
        r_result.occurrences <= r_best;
        r_result.final_digit <= (r_idx == r_lastidx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_ctl.load) begin
                r_pend <= 1'b0;
            end else if (i_ctl.divide) begin
                r_pend <= 1'b1;
            end else if (i_ctl.bump) begin
                r_pend <= 1'b0;
            end
            if (i_ctl.bump && r_pend && cnt_rd != CNT_MAX) begin
                r_cnt[addr] <= cnt_rd + 1'b1;
            end else if (i_ctl.emit) begin
                r_cnt[addr] <= '0;
            end
            if (i_ctl.init) begin
                r_idx <= '0;
            end else if (i_ctl.scan || i_ctl.emit) begin
                r_idx <= idx_next;
            end
            r_strobe <= i_ctl.emit && (cnt_rd == r_best);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> hdl/decimal_digit_mode_finder.sv
// Top level of the decimal digit mode finder: sequencer, datapath, checks.
// Depends on ddmf_pkg, ddmf_seq, ddmf_dp.
//
//  channel | ports                      | handshake
//  --------+----------------------------+--------------------------------
//  input   | i_item (value, last_elem.) | start high while busy low
//  result  | o_result (digit, occ., fin)| o_strobe high for one cycle
//
// An item is loaded, divided by ten once per decimal digit of its magnitude and then drained.
// The item marked last adds a max scan and an emit scan over the counters,
// one counter per cycle, plus a closing step.
// Reset is synchronous, active low, and clears counters and sequencer.
// Results cannot be stalled; each strobe is taken in its cycle.
`default_nettype none
module decimal_digit_mode_finder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire ddmf_pkg::t_in_item   i_item,
    output logic                      busy,
    output logic                      o_strobe,
    output ddmf_pkg::t_out_item       o_result
);
    import ddmf_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    ddmf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    ddmf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.final_digit) |=> !o_strobe)
        else $error("result after final digit");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.digit <= DIG_LAST && o_result.occurrences != '0))
        else $error("result digit or count out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");
`endif

endmodule
`default_nettype wire

>>> tb/decimal_digit_mode_finder_checker.sv
`timescale 1ns / 100ps
// Checker for the decimal digit mode finder: tallies the digits of every accepted item,
// predicts the tied most frequent digits at each last item and compares each strobed result.
// Depends on ddmf_pkg.
module decimal_digit_mode_finder_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_busy,
    input  ddmf_pkg::t_in_item   i_item,
    input  wire logic            i_strobe,
    input  ddmf_pkg::t_out_item  i_result,
    output int                   o_fail_count,
    output int                   o_pending
);
    import ddmf_pkg::*;

    logic [CNT_W-1:0] digit_tally [NUM_DIGITS];
    t_out_item        mode_digits_q [$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    initial o_pending = 0;

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_tally();
        for (int i = 0; i < NUM_DIGITS; i++)
            digit_tally[i] = '0;
    endtask

    task automatic tally_digits(input logic [31:0] raw);
        logic [31:0]      magnitude;
        logic [DIG_W-1:0] d;
        magnitude = raw[31] ? (32'd0 - raw) : raw;
        do begin
            d = DIG_W'(magnitude % 32'd10);
            if (digit_tally[d] != CNT_MAX)
                digit_tally[d] = digit_tally[d] + 1'b1;
            magnitude = magnitude / 32'd10;
        end while (magnitude != 0);
    endtask

    task automatic predict_modes();
        logic [CNT_W-1:0] top_count;
        int               last_tie;
        t_out_item        r;
        top_count = '0;
        last_tie  = 0;
        for (int i = 0; i < NUM_DIGITS; i++)
            if (digit_tally[i] > top_count)
                top_count = digit_tally[i];
        for (int i = 0; i < NUM_DIGITS; i++)
            if (digit_tally[i] == top_count)
                last_tie = i;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (digit_tally[i] == top_count) begin
                r.digit       = DIG_W'(i);
                r.occurrences = top_count;
                r.final_digit = (i == last_tie);
                mode_digits_q.push_back(r);
            end
        end
        clear_tally();
    endtask

    task automatic check_result();
        t_out_item want;
        if (mode_digits_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result digit=%0d occ=%0d final=%0b",
                                      i_result.digit, i_result.occurrences,
                                      i_result.final_digit));
        end else begin
            want = mode_digits_q.pop_front();
            if (i_result.digit !== want.digit)
                report_mismatch($sformatf("digit %0d, expected %0d",
                                          i_result.digit, want.digit));
            if (i_result.occurrences !== want.occurrences)
                report_mismatch($sformatf("occurrences %0d, expected %0d (digit %0d)",
                                          i_result.occurrences, want.occurrences,
                                          want.digit));
            if (i_result.final_digit !== want.final_digit)
                report_mismatch($sformatf("final_digit %0b, expected %0b (digit %0d)",
                                          i_result.final_digit, want.final_digit,
                                          want.digit));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tally();
            mode_digits_q.delete();
        end else begin
            if (i_strobe)
                check_result();
            if (i_start && !i_busy) begin
                tally_digits(i_item.value);
                if (i_item.last_element)
                    predict_modes();
            end
        end
        o_pending <= mode_digits_q.size();
    end

endmodule

>>> tb/decimal_digit_mode_finder_tb.sv
`timescale 1ns / 100ps
// Testbench top for the decimal digit mode finder: clock, reset, directed and random
// item stimulus, stall watchdog and verdict. Depends on ddmf_pkg and the checker module.
module decimal_digit_mode_finder_tb;
    import ddmf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 160;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int gap_max     = 13;
    int items_sent  = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    decimal_digit_mode_finder i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    decimal_digit_mode_finder_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** decimal_digit_mode_finder: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input logic [31:0] value, input logic last);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start               <= 1'b1;
        i_item.value        <= value;
        i_item.last_element <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_element();
        logic [31:0] v;
        logic [31:0] scale;
        int          k;
        scale = 32'd1;
        k = $urandom_range(1, 9);
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 9);
            2: begin
                repeat (k) scale = scale * 32'd10;
                v = $urandom % scale;
            end
            3: begin
                v = 32'd0;
                repeat (k) v = v * 32'd10 + 32'd1;
                v = v * $urandom_range(1, 9);
            end
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h8000_0001;
                    default: v = 32'd0;
                endcase
            end
            default: v = $urandom_range(10, 99);
        endcase
        if ($urandom_range(0, 1))
            v = 32'd0 - v;
        return v;
    endfunction

    initial begin
        int set_len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(32'd0, 1'b1);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'd1234567890, 1'b1);
        send_item(32'd0 - 32'd1234567890, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd10, 1'b0);
        send_item(32'd0 - 32'd100, 1'b1);
        gap_max = 0;
        send_item(32'd5, 1'b0);
        send_item(32'd55, 1'b0);
        send_item(32'd0 - 32'd9, 1'b1);
        send_item(32'd1111111111, 1'b0);
        send_item(32'd0 - 32'd2, 1'b0);
        send_item(32'd9, 1'b1);
        gap_max = 13;
        send_item(32'h8000_0001, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'd0, 1'b1);

        while (items_sent < RANDOM_ITEMS) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
            for (int i = 1; i <= set_len; i++)
                send_item(rand_element(), i == set_len);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("** decimal_digit_mode_finder: PASSED **");
        else
            $display("** decimal_digit_mode_finder: FAILED **");
        $finish;
    end

endmodule
